[src/light_seek_sweep_controller_top_macros.svh]
// ----------------------------------------------------------------------------
// Light seek sweep controller assertion macros
// Shared concurrent check forms used by the top level.
// ----------------------------------------------------------------------------
`ifndef LIGHT_SEEK_SWEEP_CONTROLLER_TOP_MACROS_SVH
`define LIGHT_SEEK_SWEEP_CONTROLLER_TOP_MACROS_SVH

// same-cycle implication, silent during reset
`define LSSC_CHECK(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, silent during reset
`define LSSC_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/lssc_pkg.sv]
// ----------------------------------------------------------------------------
// Light seek sweep controller package
// Field widths, register codes, payload and internal command types.
// ----------------------------------------------------------------------------
package lssc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DUTY_BITS   = 8;
  localparam int SWEEP_BITS  = 4;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_BITS = 1;
  localparam int QUEUE_CNT_BITS = 2;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_MIN     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_MAX     = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PAN_HOME     = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TILT_HOME    = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TILT_STEP    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_SWEEPS_TOTAL = 3'd5;

  // reset values
  localparam logic [DUTY_BITS-1:0]  RST_DUTY_MIN     = 8'd50;
  localparam logic [DUTY_BITS-1:0]  RST_DUTY_MAX     = 8'd250;
  localparam logic [DUTY_BITS-1:0]  RST_PAN_HOME     = 8'd50;
  localparam logic [DUTY_BITS-1:0]  RST_TILT_HOME    = 8'd200;
  localparam logic [DUTY_BITS-1:0]  RST_TILT_STEP    = 8'd30;
  localparam logic [SWEEP_BITS-1:0] RST_SWEEPS_TOTAL = 4'd6;
  localparam logic [DUTY_BITS-1:0]  RST_PAN_NOW      = 8'd50;
  localparam logic [DUTY_BITS-1:0]  RST_TILT_NOW     = 8'd200;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] light_sample;
    logic                   left_held;
    logic                   right_held;
    logic                   key_up;
    logic                   down_held;
    logic                   key_seek;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0]   pan_duty;
    logic [DUTY_BITS-1:0]   tilt_duty;
    logic                   seeking;
    logic [SAMPLE_BITS-1:0] brightest;
    logic                   seek_done;
  } out_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0]  duty_min;
    logic [DUTY_BITS-1:0]  duty_max;
    logic [DUTY_BITS-1:0]  pan_home;
    logic [DUTY_BITS-1:0]  tilt_home;
    logic [DUTY_BITS-1:0]  tilt_step;
    logic [SWEEP_BITS-1:0] sweeps_total;
  } cfg_t;

  // classified tick: nudge requests plus the seek restart
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   pan_inc;
    logic                   pan_dec;
    logic                   tilt_inc;
    logic                   tilt_dec;
    logic                   restart;
  } cmd_t;

  typedef struct packed {
    logic                      full;
    logic                      empty;
    logic [QUEUE_CNT_BITS-1:0] count;
  } q_stat_t;

endpackage

[src/lssc_front.sv]
// ----------------------------------------------------------------------------
// Light seek sweep front end
// Accepts ticks, decodes the key levels into a command and registers it.
// ----------------------------------------------------------------------------
module lssc_front
  import lssc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  cmd_t cmd_next;

  always_comb begin
    cmd_next.sample   = in_data.light_sample;
    cmd_next.pan_inc  = in_data.left_held;
    cmd_next.pan_dec  = in_data.right_held;
    cmd_next.tilt_inc = in_data.key_up;
    cmd_next.tilt_dec = in_data.down_held;
    cmd_next.restart  = in_data.key_seek;
  end

  assign in_ready = !cmd_valid || cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd <= cmd_next;
    end
  end

endmodule

[src/lssc_queue.sv]
// ----------------------------------------------------------------------------
// Light seek sweep command queue
// Two-entry queue between the front end and the sweep engine.
// ----------------------------------------------------------------------------
module lssc_queue
  import lssc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_valid,
  output logic    push_ready,
  input  cmd_t    push_item,
  output logic    pop_valid,
  input  logic    pop_ready,
  output cmd_t    pop_item,
  output q_stat_t stat
);

  cmd_t                      entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_BITS-1:0] wr_ptr;
  logic [QUEUE_PTR_BITS-1:0] rd_ptr;
  logic [QUEUE_CNT_BITS-1:0] count;
  logic                      push;
  logic                      pop;

  assign push_ready = (count != QUEUE_CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  assign stat.full  = !push_ready;
  assign stat.empty = !pop_valid;
  assign stat.count = count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[src/lssc_back.sv]
// ----------------------------------------------------------------------------
// Light seek sweep engine
// Applies key nudges and the seek step to the servo state, one tick a cycle
// while the output is not stalled, and holds the result in an output register.
// ----------------------------------------------------------------------------
module lssc_back
  import lssc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int SW = DUTY_BITS + 2;

  logic [DUTY_BITS-1:0]   pan_now, pan_now_next;
  logic [DUTY_BITS-1:0]   tilt_now, tilt_now_next;
  logic [SAMPLE_BITS-1:0] best_level, best_level_next;
  logic [DUTY_BITS-1:0]   best_pan, best_pan_next;
  logic [DUTY_BITS-1:0]   best_tilt, best_tilt_next;
  logic [SWEEP_BITS-1:0]  sweep_index, sweep_index_next;
  logic                   seek_active, seek_active_next;
  logic                   done;
  logic                   step;

  logic [DUTY_BITS-1:0]   pan_k1, pan_k2, tilt_k1, tilt_k2;
  logic [DUTY_BITS-1:0]   pan_s, tilt_s;
  logic signed [SW-1:0]   pan_w, pan_c1, lo_w, hi_w;
  logic                   above, below;
  logic [SWEEP_BITS-1:0]  sweep_inc;

  assign cmd_ready = !out_valid || out_ready;
  assign step      = cmd_valid && cmd_ready;
  assign lo_w      = SW'(signed'({2'b00, cfg.duty_min}));
  assign hi_w      = SW'(signed'({2'b00, cfg.duty_max}));

  always_comb begin
    // key nudges: left before right, up before down
    pan_k1  = (cmd.pan_inc && pan_now < cfg.duty_max) ? pan_now + 1'b1 : pan_now;
    pan_k2  = (cmd.pan_dec && pan_k1 > cfg.duty_min) ? pan_k1 - 1'b1 : pan_k1;
    tilt_k1 = (cmd.tilt_inc && tilt_now < cfg.duty_max) ? tilt_now + 1'b1 : tilt_now;
    tilt_k2 = (cmd.tilt_dec && tilt_k1 > cfg.duty_min) ? tilt_k1 - 1'b1 : tilt_k1;

    pan_now_next     = pan_k2;
    tilt_now_next    = tilt_k2;
    best_level_next  = best_level;
    best_pan_next    = best_pan;
    best_tilt_next   = best_tilt;
    sweep_index_next = sweep_index;
    seek_active_next = seek_active;
    done             = 1'b0;

    if (cmd.restart) begin
      pan_now_next     = cfg.pan_home;
      tilt_now_next    = cfg.tilt_home;
      best_level_next  = '0;
      sweep_index_next = '0;
      seek_active_next = 1'b1;
    end

    pan_s  = pan_now_next;
    tilt_s = tilt_now_next;
    pan_w  = SW'(signed'({2'b00, pan_s}));
    // pan may step one count past either limit
    if (!sweep_index_next[0]) begin
      if (pan_w <= hi_w) begin
        pan_w = pan_w + SW'(1);
      end
    end else begin
      if (pan_w >= lo_w) begin
        pan_w = pan_w - SW'(1);
      end
    end
    above     = pan_w > hi_w;
    below     = pan_w < lo_w;
    pan_c1    = above ? hi_w : pan_w;
    sweep_inc = sweep_index_next + 1'b1;

    if (seek_active_next) begin
      pan_now_next = pan_w[DUTY_BITS-1:0];
      if (cmd.sample > best_level_next) begin
        best_level_next = cmd.sample;
        best_pan_next   = (pan_c1 < lo_w) ? cfg.duty_min : pan_c1[DUTY_BITS-1:0];
        best_tilt_next  = tilt_s;
      end
      if (above || below) begin
        pan_now_next     = above ? cfg.duty_max : cfg.duty_min;
        sweep_index_next = sweep_inc;
        tilt_now_next    = (tilt_s > cfg.tilt_step) ? tilt_s - cfg.tilt_step : '0;
        if (sweep_inc == cfg.sweeps_total) begin
          seek_active_next = 1'b0;
          sweep_index_next = '0;
          pan_now_next     = best_pan_next;
          tilt_now_next    = best_tilt_next;
          done             = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pan_now     <= RST_PAN_NOW;
      tilt_now    <= RST_TILT_NOW;
      best_level  <= '0;
      best_pan    <= '0;
      best_tilt   <= '0;
      sweep_index <= '0;
      seek_active <= 1'b1;
      out_valid   <= 1'b0;
    end else begin
      if (step) begin
        pan_now     <= pan_now_next;
        tilt_now    <= tilt_now_next;
        best_level  <= best_level_next;
        best_pan    <= best_pan_next;
        best_tilt   <= best_tilt_next;
        sweep_index <= sweep_index_next;
        seek_active <= seek_active_next;
      end
      if (cmd_ready) begin
        out_valid <= cmd_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data.pan_duty  <= pan_now_next;
      out_data.tilt_duty <= tilt_now_next;
      out_data.seeking   <= seek_active_next;
      out_data.brightest <= best_level_next;
      out_data.seek_done <= done;
    end
  end

endmodule

[src/light_seek_sweep_controller_top.sv]
// Path: a tick passes the front end command register, the queue entry and the
// sweep engine output register. Throughput: one tick per cycle while out_ready
// holds; the sweep engine update carries servo state from tick to tick.
// Reset (synchronous): control and servo state registers return to their defaults, queue empties and
// a seek starts from pan 50, tilt 200.
// ----------------------------------------------------------------------------
// Light seek sweep controller
// Pan/tilt servo seek toward the brightest light sample, with key nudges.
// ----------------------------------------------------------------------------
`include "light_seek_sweep_controller_top_macros.svh"

module light_seek_sweep_controller_top
  import lssc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  cfg_t    cfg;
  logic    f_valid, f_ready;
  cmd_t    f_cmd;
  logic    q_valid, q_ready;
  cmd_t    q_cmd;
  q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duty_min     <= RST_DUTY_MIN;
      cfg.duty_max     <= RST_DUTY_MAX;
      cfg.pan_home     <= RST_PAN_HOME;
      cfg.tilt_home    <= RST_TILT_HOME;
      cfg.tilt_step    <= RST_TILT_STEP;
      cfg.sweeps_total <= RST_SWEEPS_TOTAL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DUTY_MIN:     cfg.duty_min     <= cfg_data[DUTY_BITS-1:0];
        CFG_DUTY_MAX:     cfg.duty_max     <= cfg_data[DUTY_BITS-1:0];
        CFG_PAN_HOME:     cfg.pan_home     <= cfg_data[DUTY_BITS-1:0];
        CFG_TILT_HOME:    cfg.tilt_home    <= cfg_data[DUTY_BITS-1:0];
        CFG_TILT_STEP:    cfg.tilt_step    <= cfg_data[DUTY_BITS-1:0];
        CFG_SWEEPS_TOTAL: cfg.sweeps_total <= cfg_data[SWEEP_BITS-1:0];
        default:          ;  // drop writes to unknown indexes
      endcase
    end
  end

  lssc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  lssc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_cmd),
    .stat       (q_stat)
  );

  lssc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  `LSSC_CHECK(a_done_ends_seek, clk, rst, out_valid && out_data.seek_done, !out_data.seeking, "seek_done reported while still seeking")
  `LSSC_CHECK(a_stall_only_when_full, clk, rst, !in_ready, f_valid && q_stat.full, "input stalled with room in the queue")
  `LSSC_CHECK(a_queue_bound, clk, rst, 1'b1, q_stat.count <= QUEUE_CNT_BITS'(QUEUE_DEPTH), "queue count beyond its depth")

endmodule
